### hdl/string_escape_decoder_core_assert.svh
// ---------------------------------------------------------------------------
// string_escape_decoder_core_assert.svh
// assertion macros shared by the string escape decoder
// ---------------------------------------------------------------------------
`ifndef STRING_ESCAPE_DECODER_CORE_ASSERT_SVH
`define STRING_ESCAPE_DECODER_CORE_ASSERT_SVH

// clocked assertion, switched off while reset is active
`define SED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define SED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/sed_pkg.sv
// ---------------------------------------------------------------------------
// sed_pkg
// shared types and status codes of the string escape decoder
// ---------------------------------------------------------------------------
package sed_pkg;

  // result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_CLOSED = 3'd1;
  localparam logic [2:0] ST_INTERP = 3'd2;
  localparam logic [2:0] ST_UNTERM = 3'd3;
  localparam logic [2:0] ST_BADHEX = 3'd4;
  localparam logic [2:0] ST_BADUNI = 3'd5;
  localparam logic [2:0] ST_BADESC = 3'd6;

  localparam logic [7:0] DELIM_RESET = 8'd34;
  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } sed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } sed_out_t;

  // results of one input byte, handed from decoder to output buffer
  typedef struct packed {
    logic [2:0]                 count;
    sed_out_t [MAX_RES-1:0]     res;
  } sed_load_t;

endpackage

### hdl/sed_decoder.sv
// ---------------------------------------------------------------------------
// sed_decoder
// escape state machine: turns one source byte into up to four results
// ---------------------------------------------------------------------------
module sed_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  sed_pkg::sed_in_t in_data_i,
  output sed_pkg::sed_load_t load_o
);
  import sed_pkg::*;

  localparam logic [2:0] M_PLAIN  = 3'd0;
  localparam logic [2:0] M_DOLLAR = 3'd1;
  localparam logic [2:0] M_ESC    = 3'd2;
  localparam logic [2:0] M_HEX1   = 3'd3;
  localparam logic [2:0] M_HEX2   = 3'd4;
  localparam logic [2:0] M_DEC    = 3'd5;
  localparam logic [2:0] M_UNI    = 3'd6;

  localparam logic [24:0] CP_LIMIT = 25'h110000;

  typedef struct packed {
    logic       emit;
    sed_out_t   res;
    logic [2:0] mode;
  } plain_t;

  logic [7:0]  delim_q;
  logic [2:0]  mode_q, mode_d;
  logic [3:0]  hex_q, hex_d;
  logic [20:0] cp_q, cp_d;
  logic [3:0]  digits_q, digits_d;
  logic        long_q, long_d;
  logic [6:0]  dec_q, dec_d;

  function automatic sed_out_t byte_res(input logic [7:0] b);
    sed_out_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.status     = ST_DATA;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic sed_out_t end_res(input logic [2:0] st);
    sed_out_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b0;
    r.status     = st;
    r.last       = 1'b0;
    return r;
  endfunction

  // {is hex digit, value}
  function automatic logic [4:0] hex_nib(input logic [7:0] c, input logic eof);
    logic [4:0] r;
    r = 5'd0;
    if (!eof) begin
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // simple escapes: {known, value}
  function automatic logic [8:0] esc_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h60:   r = {1'b1, 8'h60};
      8'h30:   r = {1'b1, 8'h00};
      8'h24:   r = {1'b1, 8'h24};
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h65:   r = {1'b1, 8'd27};
      8'h66:   r = {1'b1, 8'd12};
      8'h6E:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // handling of a byte in the plain body
  function automatic plain_t plain_step(input logic [7:0] c, input logic eof,
                                        input logic [7:0] delim);
    plain_t p;
    p.emit = 1'b1;
    p.mode = M_PLAIN;
    p.res  = byte_res(c);
    if (eof) p.res = end_res(ST_UNTERM);
    else if (c == delim) p.res = end_res(ST_CLOSED);
    else if (c == 8'h24) begin
      p.emit = 1'b0;
      p.mode = M_DOLLAR;
    end else if (c == 8'h0A || c == 8'h0D) p.res = end_res(ST_UNTERM);
    else if (c == 8'h5C) begin
      p.emit = 1'b0;
      p.mode = M_ESC;
    end
    return p;
  endfunction

  logic [7:0]  c;
  logic        eof;
  plain_t      pl;
  logic [4:0]  nib;
  logic [8:0]  esc;
  logic        is_dig;
  logic [9:0]  dec_t;
  logic [24:0] uni_t;
  logic [20:0] cp_n;
  logic [3:0]  dig_n;
  logic        uni_done;
  sed_out_t [MAX_RES-1:0] res;
  logic [2:0]  cnt;

  assign c   = in_data_i.in_byte;
  assign eof = in_data_i.end_of_input;

  // datapath terms used by several modes
  always_comb begin
    pl       = plain_step(c, eof, delim_q);
    nib      = hex_nib(c, eof);
    esc      = esc_map(c);
    is_dig   = !eof && c >= 8'h30 && c <= 8'h39;
    dec_t    = {dec_q, 3'b000} + {2'b00, dec_q, 1'b0} + {6'd0, c[3:0]};
    uni_t    = {cp_q, nib[3:0]};
    cp_n     = uni_t[20:0];
    dig_n    = digits_q + 4'd1;
    uni_done = long_q ? (dig_n >= 4'd8) : (dig_n >= 4'd4);
  end

  // next state and results of one byte
  always_comb begin
    mode_d   = mode_q;
    hex_d    = hex_q;
    cp_d     = cp_q;
    digits_d = digits_q;
    long_d   = long_q;
    dec_d    = dec_q;
    res      = '0;
    cnt      = 3'd0;
    case (mode_q)
      M_DOLLAR: begin
        if (!eof && c == 8'h7B) begin
          res[0] = end_res(ST_INTERP);
          cnt    = 3'd1;
          mode_d = M_PLAIN;
        end else begin
          res[0] = byte_res(8'h24);
          res[1] = pl.res;
          cnt    = pl.emit ? 3'd2 : 3'd1;
          mode_d = pl.mode;
        end
      end
      M_ESC: begin
        cnt    = 3'd1;
        mode_d = M_PLAIN;
        if (eof) res[0] = end_res(ST_UNTERM);
        else if (esc[8]) res[0] = byte_res(esc[7:0]);
        else if (c == 8'h78) begin
          cnt    = 3'd0;
          mode_d = M_HEX1;
        end else if (c == 8'h75 || c == 8'h55) begin
          cnt      = 3'd0;
          mode_d   = M_UNI;
          long_d   = (c == 8'h55);
          digits_d = 4'd0;
          cp_d     = 21'd0;
        end else if (c >= 8'h31 && c <= 8'h39) begin
          cnt      = 3'd0;
          mode_d   = M_DEC;
          dec_d    = {3'b000, c[3:0]};
          digits_d = 4'd1;
        end else res[0] = end_res(ST_BADESC);
      end
      M_HEX1: begin
        if (!nib[4]) begin
          res[0] = end_res(ST_BADHEX);
          cnt    = 3'd1;
          mode_d = M_PLAIN;
        end else begin
          hex_d  = nib[3:0];
          mode_d = M_HEX2;
        end
      end
      M_HEX2: begin
        cnt    = 3'd1;
        mode_d = M_PLAIN;
        res[0] = nib[4] ? byte_res({hex_q, nib[3:0]}) : end_res(ST_BADHEX);
      end
      M_DEC: begin
        if (is_dig) begin
          if (digits_q < 4'd2) begin
            dec_d    = dec_t[6:0];
            digits_d = 4'd2;
          end else begin
            cnt    = 3'd1;
            mode_d = M_PLAIN;
            res[0] = (dec_t > 10'd255) ? end_res(ST_BADESC) : byte_res(dec_t[7:0]);
          end
        end else begin
          res[0] = byte_res({1'b0, dec_q});
          res[1] = pl.res;
          cnt    = pl.emit ? 3'd2 : 3'd1;
          mode_d = pl.mode;
        end
      end
      M_UNI: begin
        if (!nib[4] || uni_t >= CP_LIMIT) begin
          res[0] = end_res(ST_BADUNI);
          cnt    = 3'd1;
          mode_d = M_PLAIN;
        end else begin
          cp_d     = cp_n;
          digits_d = dig_n;
          if (uni_done) begin
            mode_d = M_PLAIN;
            // utf-8 re-encoding by code point range
            if (cp_n < 21'h80) begin
              res[0] = byte_res(cp_n[7:0]);
              cnt    = 3'd1;
            end else if (cp_n < 21'h800) begin
              res[0] = byte_res({3'b110, cp_n[10:6]});
              res[1] = byte_res({2'b10, cp_n[5:0]});
              cnt    = 3'd2;
            end else if (cp_n < 21'h10000) begin
              if (cp_n[20:11] == 10'h01B) begin
                res[0] = end_res(ST_BADUNI);
                cnt    = 3'd1;
              end else begin
                res[0] = byte_res({4'b1110, cp_n[15:12]});
                res[1] = byte_res({2'b10, cp_n[11:6]});
                res[2] = byte_res({2'b10, cp_n[5:0]});
                cnt    = 3'd3;
              end
            end else begin
              res[0] = byte_res({5'b11110, cp_n[20:18]});
              res[1] = byte_res({2'b10, cp_n[17:12]});
              res[2] = byte_res({2'b10, cp_n[11:6]});
              res[3] = byte_res({2'b10, cp_n[5:0]});
              cnt    = 3'd4;
            end
          end
        end
      end
      default: begin
        res[0] = pl.res;
        cnt    = pl.emit ? 3'd1 : 3'd0;
        mode_d = pl.mode;
      end
    endcase

    // back to the plain body clears the escape state
    if (mode_d == M_PLAIN) begin
      hex_d    = 4'd0;
      cp_d     = 21'd0;
      digits_d = 4'd0;
      long_d   = 1'b0;
      dec_d    = 7'd0;
    end

    // flag the final result of this byte
    case (cnt)
      3'd1:    res[0].last = 1'b1;
      3'd2:    res[1].last = 1'b1;
      3'd3:    res[2].last = 1'b1;
      3'd4:    res[3].last = 1'b1;
      default: ;
    endcase
  end

  assign load_o.count = cnt;
  assign load_o.res   = res;

  // delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  // escape state, advanced on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_PLAIN;
      hex_q    <= 4'd0;
      cp_q     <= 21'd0;
      digits_q <= 4'd0;
      long_q   <= 1'b0;
      dec_q    <= 7'd0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      hex_q    <= hex_d;
      cp_q     <= cp_d;
      digits_q <= digits_d;
      long_q   <= long_d;
      dec_q    <= dec_d;
    end
  end

endmodule

### hdl/sed_out_buf.sv
// ---------------------------------------------------------------------------
// sed_out_buf
// result register: holds the results of one byte and shifts them out
// ---------------------------------------------------------------------------
module sed_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_en_i,
  input  sed_pkg::sed_load_t  load_i,
  input  logic                out_stall_i,
  output logic                ready_o,
  output logic                out_valid_o,
  output sed_pkg::sed_out_t   out_data_o
);
  import sed_pkg::*;

  sed_out_t [MAX_RES-1:0] buf_q;
  logic [2:0]             count_q;
  logic                   take;

  assign take        = (count_q != 3'd0) && !out_stall_i;
  // free now, or the last held result leaves in this cycle
  assign ready_o     = (count_q == 3'd0) || ((count_q == 3'd1) && !out_stall_i);
  assign out_valid_o = (count_q != 3'd0);
  assign out_data_o  = buf_q[0];

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else if (load_en_i) begin
      count_q <= load_i.count;
    end else if (take) begin
      count_q <= count_q - 3'd1;
    end
  end

  // result slots, head in slot zero
  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      buf_q <= load_i.res;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
      buf_q[MAX_RES-1] <= '0;
    end
  end

endmodule

### hdl/string_escape_decoder_core.sv
// ---------------------------------------------------------------------------
// string_escape_decoder_core
// decodes the body of a quoted string literal into bytes and end status
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (sed_in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (sed_out_t)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (delimiter)
//
//  One source byte is taken per cycle while the result register is ready;
//  its results land in a four-slot result register in the cycle after it
//  is taken and leave one per cycle unless out_stall_i holds them back.
//  A byte causing n results (n up to 4, for a four byte utf-8 sequence) stalls the input until its last result leaves.
//  The next byte is taken in the cycle the last held result leaves.
//  Reset sets the plain body mode, an empty result register and the
//  double quote delimiter.
// ---------------------------------------------------------------------------
module string_escape_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sed_pkg::sed_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sed_pkg::sed_out_t  out_data_o
);
  import sed_pkg::*;

  `include "string_escape_decoder_core_assert.svh"

  sed_load_t load;
  logic      ready;
  logic      accept;
  logic      load_en;

  // input transfer and result load
  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;
  assign load_en    = accept && (load.count != 3'd0);

  sed_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .load_o      (load)
  );

  sed_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_en_i   (load_en),
    .load_i      (load),
    .out_stall_i (out_stall_i),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // results of one byte leave without gaps
  `SED_ASSERT(a_no_gap,
              out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o,
              "result sequence broken before last")
  // a new byte is never taken while earlier results are still pending
  `SED_ASSERT(a_no_overrun,
              accept |-> !out_valid_o || (out_data_o.last && !out_stall_i),
              "input taken over pending results")
  // an end status always closes the results of its byte
  `SED_ASSERT(a_end_last,
              out_valid_o && !out_data_o.byte_valid |->
                out_data_o.last && out_data_o.status != ST_DATA,
              "end status not final")
  // nothing is offered in the cycle after reset
  `SED_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the string escape decoder core
//
// A short directed table runs first: byte extremes, every end status and the
// escape forms, with hand-written results where they are obvious. Random
// literal bodies follow, mostly well-formed with random content and some
// raw noise, under seven delimiter settings and three idle mixes on both
// channels. Each accepted byte is run through a local decoder model, and
// every output transfer is compared field by field with the oldest result
// still outstanding.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import sed_pkg::*;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned TIMEOUT_NS  = 2_000_000;
  localparam int unsigned PHASE_BYTES = 40;
  localparam int unsigned N_PHASES    = 7;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned HOLD_CYC    = 80;
  localparam logic [7:0]  CH_BTICK    = 8'h60;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam logic [7:0]  CH_CR       = 8'h0D;

  // literal decoding modes of the local model
  typedef enum logic [3:0] {
    MD_PLAIN, MD_DOLLAR, MD_ESC, MD_HEX1, MD_HEX2, MD_DEC, MD_UNI
  } lit_mode_e;

  // directed row: source byte plus a hand-written final result where typed
  typedef struct packed {
    logic [7:0] in_byte;
    logic       eoi;
    logic       typed;
    logic [2:0] st;
    logic [7:0] ob;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  sed_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  sed_out_t out_data_o;

  // model state
  lit_mode_e   p_mode;
  logic [7:0]  p_delim;
  logic [7:0]  p_hex_hi;
  logic [20:0] p_cp;
  logic [3:0]  p_digits;
  logic        p_long;
  logic [6:0]  p_dec;

  sed_out_t step_q[$];
  sed_out_t decoded_q[$];
  sed_in_t  src_q[$];

  int  snd_idle = 19;
  int  rcv_idle = 55;
  bit  hold_req = 1'b0;
  int  err_cnt = 0;
  int  bytes_sent = 0;
  int  res_checked = 0;
  int  cfg_writes = 0;
  int  status_cnt [8] = '{default: 0};

  string simple_esc = "\"'\\0$abefnrtv";

  logic [7:0] delim_set [7] = '{8'h27, 8'h60, 8'h00, 8'hFF, 8'h24, 8'h5C, 8'h0A};

  dir_row_t dir_tab [28] = '{
    '{8'h00, 1'b0, 1'b1, ST_DATA,   8'h00},
    '{8'hFF, 1'b0, 1'b1, ST_DATA,   8'hFF},
    '{"$",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"A",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"$",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"{",   1'b0, 1'b1, ST_INTERP, 8'h00},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{"n",   1'b0, 1'b1, ST_DATA,   8'h0A},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{"q",   1'b0, 1'b1, ST_BADESC, 8'h00},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{"2",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"5",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"6",   1'b0, 1'b1, ST_BADESC, 8'h00},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{"7",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"\"",  1'b0, 1'b1, ST_CLOSED, 8'h00},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{"x",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"g",   1'b0, 1'b1, ST_BADHEX, 8'h00},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{"u",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{"z",   1'b0, 1'b1, ST_BADUNI, 8'h00},
    '{"$",   1'b0, 1'b0, ST_DATA,   8'h00},
    '{8'hFF, 1'b1, 1'b1, ST_UNTERM, 8'h00},
    '{CH_LF, 1'b0, 1'b1, ST_UNTERM, 8'h00},
    '{"\\",  1'b0, 1'b0, ST_DATA,   8'h00},
    '{8'h00, 1'b1, 1'b1, ST_UNTERM, 8'h00}
  };

  string_escape_decoder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------
  task automatic clear_esc();
    p_mode   = MD_PLAIN;
    p_hex_hi = '0;
    p_cp     = '0;
    p_digits = '0;
    p_long   = 1'b0;
    p_dec    = '0;
  endtask

  task automatic put_byte(input int b);
    step_q.push_back('{b[7:0], 1'b1, ST_DATA, 1'b0});
  endtask

  task automatic put_end(input logic [2:0] st);
    step_q.push_back('{8'h00, 1'b0, st, 1'b0});
    clear_esc();
  endtask

  // hex digit value, -1 for anything else or end of input
  function automatic int nibble_of(input logic [7:0] c, input logic eoi);
    if (eoi) return -1;
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // byte in the plain body; delimiter wins over every other meaning but end of input
  task automatic plain_step(input logic [7:0] c, input logic eoi);
    if (eoi) put_end(ST_UNTERM);
    else if (c == p_delim) put_end(ST_CLOSED);
    else if (c == "$") p_mode = MD_DOLLAR;
    else if (c == CH_LF || c == CH_CR) put_end(ST_UNTERM);
    else if (c == "\\") p_mode = MD_ESC;
    else put_byte(int'(c));
  endtask

  task automatic decode_source_byte(input sed_in_t it, output int n);
    logic [7:0] c;
    logic       eoi;
    int         nib;
    int         t;
    c   = it.in_byte;
    eoi = it.end_of_input;
    step_q.delete();
    case (p_mode)
      MD_DOLLAR: begin
        if (!eoi && c == "{") begin
          put_end(ST_INTERP);
        end else begin
          put_byte(int'("$"));
          p_mode = MD_PLAIN;
          plain_step(c, eoi);
        end
      end
      MD_ESC: begin
        if (eoi) begin
          put_end(ST_UNTERM);
        end else if (c == "x") begin
          p_mode = MD_HEX1;
        end else if (c == "u" || c == "U") begin
          p_mode   = MD_UNI;
          p_long   = (c == "U");
          p_digits = '0;
          p_cp     = '0;
        end else if (c >= "1" && c <= "9") begin
          p_mode   = MD_DEC;
          p_dec    = 7'(int'(c) - int'("0"));
          p_digits = 4'd1;
        end else begin
          t = -1;
          case (c)
            "\"", "'", "\\", "$", CH_BTICK: t = int'(c);
            "0": t = 0;
            "a": t = 7;
            "b": t = 8;
            "e": t = 27;
            "f": t = 12;
            "n": t = 10;
            "r": t = 13;
            "t": t = 9;
            "v": t = 11;
            default: t = -1;
          endcase
          if (t < 0) begin
            put_end(ST_BADESC);
          end else begin
            put_byte(t);
            clear_esc();
          end
        end
      end
      MD_HEX1: begin
        nib = nibble_of(c, eoi);
        if (nib < 0) begin
          put_end(ST_BADHEX);
        end else begin
          p_hex_hi = {nib[3:0], 4'h0};
          p_mode   = MD_HEX2;
        end
      end
      MD_HEX2: begin
        nib = nibble_of(c, eoi);
        if (nib < 0) begin
          put_end(ST_BADHEX);
        end else begin
          put_byte(int'(p_hex_hi) | nib);
          clear_esc();
        end
      end
      MD_DEC: begin
        if (!eoi && c >= "0" && c <= "9") begin
          t = int'(p_dec) * 10 + int'(c) - int'("0");
          if (p_digits < 4'd2) begin
            p_dec    = t[6:0];
            p_digits = 4'd2;
          end else if (t > 255) begin
            put_end(ST_BADESC);
          end else begin
            put_byte(t);
            clear_esc();
          end
        end else begin
          // short decimal: value first, then the byte as plain body
          put_byte(int'(p_dec));
          clear_esc();
          plain_step(c, eoi);
        end
      end
      MD_UNI: begin
        nib = nibble_of(c, eoi);
        t   = (int'(p_cp) << 4) | nib;
        if (nib < 0 || t >= 'h110000) begin
          put_end(ST_BADUNI);
        end else begin
          p_cp     = t[20:0];
          p_digits = p_digits + 4'd1;
          if (p_digits >= (p_long ? 4'd8 : 4'd4)) begin
            // re-encode the code point as utf-8
            if (t < 'h80) begin
              put_byte(t);
            end else if (t < 'h800) begin
              put_byte('hC0 | (t >> 6));
              put_byte('h80 | (t & 'h3F));
            end else if (t < 'h10000) begin
              if (t >= 'hD800 && t < 'hE000) begin
                put_end(ST_BADUNI);
              end else begin
                put_byte('hE0 | (t >> 12));
                put_byte('h80 | ((t >> 6) & 'h3F));
                put_byte('h80 | (t & 'h3F));
              end
            end else begin
              put_byte('hF0 | ((t >> 18) & 'h07));
              put_byte('h80 | ((t >> 12) & 'h3F));
              put_byte('h80 | ((t >> 6) & 'h3F));
              put_byte('h80 | (t & 'h3F));
            end
            clear_esc();
          end
        end
      end
      default: begin
        p_mode = MD_PLAIN;
        plain_step(c, eoi);
      end
    endcase
    n = step_q.size();
    if (n > 0) step_q[n-1].last = 1'b1;
    foreach (step_q[i]) begin
      status_cnt[step_q[i].status]++;
      decoded_q.push_back(step_q[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // random literal bodies
  // ---------------------------------------------------------------------------
  task automatic push_src(input int b);
    src_q.push_back('{b[7:0], 1'b0});
  endtask

  task automatic push_eoi();
    int r;
    r = $urandom;
    src_q.push_back('{r[7:0], 1'b1});
  endtask

  // byte that stays a plain data byte under the current delimiter
  function automatic int plain_char();
    int c;
    do c = $urandom_range(255);
    while (c == int'(p_delim) || c == int'("$") || c == int'("\\") || c == int'("{") ||
           c == int'(CH_LF) || c == int'(CH_CR));
    return c;
  endfunction

  function automatic int hex_char(input int nib);
    if (nib < 10) return int'("0") + nib;
    return ($urandom_range(1) ? int'("a") : int'("A")) + nib - 10;
  endfunction

  // true for a byte that starts an escape form
  function automatic bit esc_start(input int c);
    string starts;
    starts = "\"'\\0$abefnrtvxuU123456789";
    if (c == int'(CH_BTICK)) return 1'b1;
    for (int i = 0; i < starts.len(); i++)
      if (c == int'(starts[i])) return 1'b1;
    return 1'b0;
  endfunction

  // hex digits of a value, sometimes with one broken digit
  task automatic push_hex(input int nd, input int v);
    int bad_pos;
    int c;
    bad_pos = ($urandom_range(9) == 0) ? $urandom_range(nd - 1) : -1;
    for (int i = nd - 1; i >= 0; i--) begin
      if (i == bad_pos) begin
        do c = $urandom_range(255); while (nibble_of(c[7:0], 1'b0) >= 0);
        push_src(c);
      end else begin
        push_src(hex_char((v >> (4 * i)) & 'hF));
      end
    end
  endtask

  task automatic gen_literal();
    int kind;
    int nd;
    int cp;
    int c;
    int idx;
    // raw noise now and then
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(15) == 0) push_eoi();
        else push_src($urandom_range(255));
      end
      return;
    end
    repeat ($urandom_range(0, 10)) begin
      kind = $urandom_range(9);
      if (kind >= 3 && p_delim == "\\") kind = 0;
      if (kind == 2 && p_delim == "$") kind = 0;
      case (kind)
        2: begin
          push_src(int'("$"));
          push_src(plain_char());
        end
        3, 4: begin
          push_src(int'("\\"));
          idx = $urandom_range(simple_esc.len());
          push_src(idx == simple_esc.len() ? int'(CH_BTICK) : int'(simple_esc[idx]));
        end
        5: begin
          push_src(int'("\\"));
          push_src(int'("x"));
          push_hex(2, $urandom_range(255));
        end
        6: begin
          nd = $urandom_range(1, 3);
          push_src(int'("\\"));
          push_src(int'("0") + (nd == 3 ? $urandom_range(1, 3) : $urandom_range(1, 9)));
          repeat (nd - 1) push_src(int'("0") + $urandom_range(9));
        end
        7: begin
          case ($urandom_range(4))
            0: cp = $urandom_range('h7F);
            1: cp = $urandom_range('h80, 'h7FF);
            2: cp = $urandom_range('h800, 'hD7FF);
            3: cp = $urandom_range('hD800, 'hDFFF);
            default: cp = $urandom_range('hE000, 'hFFFF);
          endcase
          push_src(int'("\\"));
          push_src(int'("u"));
          push_hex(4, cp);
        end
        8: begin
          case ($urandom_range(3))
            0: cp = $urandom_range('hFFFF);
            1: cp = $urandom_range('h10000, 'h10FFFF);
            2: cp = $urandom_range(1) ? 'h10FFFF : 'h110000;
            default: cp = $urandom;
          endcase
          push_src(int'("\\"));
          push_src(int'("U"));
          push_hex(8, cp);
        end
        default: push_src(plain_char());
      endcase
    end
    // how the body ends
    kind = $urandom_range(99);
    if (kind < 50) begin
      push_src(int'(p_delim));
    end else if (kind < 65) begin
      push_src(int'("$"));
      push_src(int'("{"));
    end else if (kind < 75) begin
      push_eoi();
    end else if (kind < 85) begin
      push_src($urandom_range(1) ? int'(CH_LF) : int'(CH_CR));
    end else if (kind < 95) begin
      do c = $urandom_range(255); while (esc_start(c));
      push_src(int'("\\"));
      push_src(c);
    end else begin
      push_src(int'("$"));
      push_eoi();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic send_item(input sed_in_t it, output int n);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_source_byte(it, n);
    bytes_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  task automatic set_delimiter(input logic [7:0] d);
    // a byte without results may still be in flight
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    p_delim = d;
    cfg_writes++;
  endtask

  task automatic run_phase(input int hold_at, input int pause_at);
    int k;
    int n;
    k = 0;
    while (src_q.size() < PHASE_BYTES) gen_literal();
    while (src_q.size() != 0) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) wait_drained();
      send_item(src_q.pop_front(), n);
      k++;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall plus an occasional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    sed_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transfer, expected none, got %h", $time, out_data_o);
      end else begin
        want = decoded_q.pop_front();
        res_checked++;
        check_field("out_byte", want.out_byte, out_data_o.out_byte);
        check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, out_data_o.byte_valid});
        check_field("status", {5'd0, want.status}, {5'd0, out_data_o.status});
        check_field("last", {7'd0, want.last}, {7'd0, out_data_o.last});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    p_delim = DELIM_RESET;
    clear_esc();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table under the reset delimiter
    foreach (dir_tab[i]) begin
      send_item('{dir_tab[i].in_byte, dir_tab[i].eoi}, n);
      if (dir_tab[i].typed && n > 0) begin
        decoded_q[$].out_byte   = dir_tab[i].ob;
        decoded_q[$].byte_valid = (dir_tab[i].st == ST_DATA);
        decoded_q[$].status     = dir_tab[i].st;
      end
    end
    wait_drained();

    // random bodies: delimiter settings and idle mixes
    for (int ph = 0; ph < N_PHASES; ph++) begin
      snd_idle = (ph < 3) ? 19 : (ph < 5) ? 55 : 0;
      rcv_idle = (ph < 3) ? 55 : (ph < 5) ? 19 : 0;
      set_delimiter(delim_set[ph]);
      run_phase((ph == 1 || ph == 5) ? 10 : -1, (ph == 3 || ph == 6) ? 24 : -1);
    end

    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      err_cnt += decoded_q.size();
      $display("%0t: %0d expected results never arrived", $time, decoded_q.size());
    end

    $display("covered %0d source bytes, %0d results, %0d delimiter writes",
             bytes_sent, res_checked, cfg_writes);
    $display("ends: %0d closed, %0d interp, %0d unterm, %0d hex, %0d unicode, %0d escape",
             status_cnt[ST_CLOSED], status_cnt[ST_INTERP], status_cnt[ST_UNTERM],
             status_cnt[ST_BADHEX], status_cnt[ST_BADUNI], status_cnt[ST_BADESC]);
    if (err_cnt == 0) begin
      $display("string_escape_decoder_core regression: pass");
    end else begin
      $display("string_escape_decoder_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still outstanding", $time, decoded_q.size());
    $display("string_escape_decoder_core regression: fail");
    $finish;
  end

endmodule

### string_escape_decoder_core.f
+incdir+hdl
hdl/sed_pkg.sv
hdl/sed_decoder.sv
hdl/sed_out_buf.sv
hdl/string_escape_decoder_core.sv
tb/tb.sv
